// ===== src/abdp_pkg.sv =====
package abdp_pkg;

  localparam int COST_W           = 32;
  localparam int SUM_W            = 36;
  localparam int OUT_W            = 35;
  localparam int IDX_W            = 3;
  localparam int CNT_W            = 4;
  localparam int ITEM_COUNT_RESET = 8;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  typedef logic signed [COST_W-1:0] cost_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [OUT_W-1:0]  result_t;
  typedef logic        [IDX_W-1:0]  index_t;
  typedef logic        [CNT_W-1:0]  count_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ISSUE,
    S_DRAIN,
    S_WRITE,
    S_EMIT
  } state_t;

endpackage

// ===== src/abdp_if.sv =====
interface abdp_in_if;
  import abdp_pkg::*;
  logic   valid;
  logic   ready;
  logic   action;
  index_t item_index;
  index_t slot_index;
  cost_t  cost_value;
  modport source (output valid, action, item_index, slot_index, cost_value, input ready);
  modport sink   (input valid, action, item_index, slot_index, cost_value, output ready);
endinterface

interface abdp_out_if;
  import abdp_pkg::*;
  logic    valid;
  logic    ready;
  result_t min_cost;
  modport source (output valid, min_cost, input ready);
  modport sink   (input valid, min_cost, output ready);
endinterface

interface abdp_cfg_if;
  import abdp_pkg::*;
  logic   valid;
  logic   ready;
  count_t item_count;
  modport source (output valid, item_count, input ready);
  modport sink   (input valid, item_count, output ready);
endinterface

// ===== src/assignment_bitmask_dp_core.sv =====
// Min-cost assignment solver over a subset table. A load item writes one signed cost
// entry; loads may follow each other every cycle while no solve is in progress. A solve
// item works through every nonzero subset of the n items before its result is offered
// (zero when n is zero), and no input item is accepted meanwhile. Its pace is set by the
// single adder and comparator, which takes one candidate per cycle, and by the one read
// port of the subset memory, plus a drain and a write-back step for every subset. The
// result register lets the next loads proceed while a result waits to be taken.
module assignment_bitmask_dp_core #(
  parameter int MAX_ITEMS = 8
) (
  input logic       clk,
  input logic       rst_n,
  abdp_in_if.sink   in_ch,
  abdp_out_if.source out_ch,
  abdp_cfg_if.sink  cfg_ch
);
  import abdp_pkg::*;

  localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW   = $clog2(MAX_ITEMS + 1);
  localparam int CAW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS * MAX_ITEMS) : 1;
  localparam int MW   = MAX_ITEMS;
  localparam int NRST = (ITEM_COUNT_RESET > MAX_ITEMS) ? MAX_ITEMS : ITEM_COUNT_RESET;

  state_t           state_r, state_nxt;
  logic [MW-1:0]    mask_r, mask_nxt;
  logic [IW-1:0]    item_r, item_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  sum_t             acc_r, acc_nxt;
  logic             acc_ok_r, acc_ok_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_cost_r, out_cost_nxt;

  logic             cost_we;
  logic [CAW-1:0]   cost_waddr;
  logic [CAW-1:0]   cost_raddr;
  logic [COST_W-1:0] cost_rdata;
  logic             best_we;
  logic [MW-1:0]    best_waddr;
  sum_t             best_wdata;
  logic [MW-1:0]    best_raddr;
  logic [SUM_W-1:0] best_rdata;

  logic             in_acc;
  logic             load_ok;
  logic [31:0]      load_addr;
  logic [31:0]      read_addr;
  logic [MW-1:0]    full_mask;
  sum_t             cand;

  function automatic logic [IW-1:0] slot_of(input logic [MW-1:0] m);
    logic [NW-1:0] c;
    logic [NW-1:0] s;
    c = '0;
    for (int k = 0; k < MW; k++) begin
      c = c + NW'(m[k]);
    end
    s = c - NW'(1);
    return s[IW-1:0];
  endfunction

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_ok   = (32'(in_ch.item_index) < 32'(MAX_ITEMS)) &&
                     (32'(in_ch.slot_index) < 32'(MAX_ITEMS));
  assign load_addr = 32'(in_ch.item_index) * 32'(MAX_ITEMS) + 32'(in_ch.slot_index);
  assign read_addr = 32'(item_r) * 32'(MAX_ITEMS) + 32'(slot_r);
  assign cost_we    = in_acc && (in_ch.action == ACT_LOAD) && load_ok;
  assign cost_waddr = load_addr[CAW-1:0];
  assign cost_raddr = read_addr[CAW-1:0];
  assign best_raddr = mask_r & ~(MW'(1) << item_r);
  assign full_mask  = ~({MW{1'b1}} << n_r);
  assign cand = sum_t'(signed'(best_rdata)) + sum_t'(signed'(cost_rdata));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.min_cost = out_cost_r;

  abdp_ram #(.DW(COST_W), .AW(CAW)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (in_ch.cost_value),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  abdp_ram #(.DW(SUM_W), .AW(MW)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= NW'(NRST);
      acc_ok_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      acc_ok_r    <= acc_ok_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r     <= mask_nxt;
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    acc_r      <= acc_nxt;
    out_cost_r <= out_cost_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    item_nxt      = item_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    acc_ok_nxt    = acc_ok_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_cost_nxt  = out_cost_r;
    best_we       = 1'b0;
    best_waddr    = mask_r;
    best_wdata    = acc_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      if (32'(cfg_ch.item_count) > 32'(MAX_ITEMS)) begin
        n_nxt = NW'(MAX_ITEMS);
      end else begin
        n_nxt = NW'(cfg_ch.item_count);
      end
    end

    if (rd_vld_r) begin
      if (!acc_ok_r || (cand < acc_r)) begin
        acc_nxt = cand;
      end
      acc_ok_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.action == ACT_SOLVE)) begin
          if (n_r == '0) begin
            acc_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        best_we    = 1'b1;
        best_waddr = '0;
        best_wdata = '0;
        mask_nxt   = MW'(1);
        item_nxt   = '0;
        slot_nxt   = '0;
        acc_ok_nxt = 1'b0;
        state_nxt  = S_ISSUE;
      end
      S_ISSUE: begin
        rd_vld_nxt = mask_r[item_r];
        item_nxt   = item_r + IW'(1);
        if (NW'(item_r) == n_r - NW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        best_we    = 1'b1;
        acc_ok_nxt = 1'b0;
        if (mask_r == full_mask) begin
          state_nxt = S_EMIT;
        end else begin
          mask_nxt  = mask_r + MW'(1);
          slot_nxt  = slot_of(mask_r + MW'(1));
          item_nxt  = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = acc_r[OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result offered outside the emit step");

  a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_ISSUE))
    else $error("candidate data without a read issue");

  a_item_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (NW'(item_r) < n_r))
    else $error("item counter beyond item count");

  a_wr_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> acc_ok_r)
    else $error("subset written without any candidate");

endmodule

// ===== src/abdp_ram.sv =====
module abdp_ram #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
